// ===== rtl/iqmaf_pkg.sv =====
// shared types and constants of the i/q outlier, median and average filter
`default_nettype none
package iqmaf_pkg;

	localparam int SAMPLE_W  = 15;
	localparam int IN_W      = 16;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 8;
	localparam int AVG_W     = 23;
	localparam int MAG_W     = 24;
	localparam int FRAC_W    = 8;
	localparam int FENCE_W   = 25;
	localparam int SQR_W     = 46;
	localparam int SQ_W      = 48;
	localparam int ROOT_W    = 24;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 15'h7FFF;
	localparam logic [IN_W-1:0]     IN_MOST_NEG = 16'h8000;
	localparam logic [CFG_W-1:0]    SINCE_MAX = 8'hFF;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_IQR_MULT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 8'd1;
	localparam logic [CFG_W-1:0]     IQR_MULT_RST = 8'd24;
	localparam logic [CFG_W-1:0]     PERIOD_RST   = 8'd10;

	// control handed to a ranking chain
	typedef struct packed {
		logic push;
		logic start;
	} rank_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QSTART,
		S_QWAIT,
		S_FMUL,
		S_FCMP,
		S_MSTART,
		S_MWAIT,
		S_AVG,
		S_DSTART,
		S_DWAIT,
		S_SQI,
		S_SQQ,
		S_RSTART,
		S_RWAIT,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/iq_outlier_median_average_filter.sv =====
// top level of the i/q outlier rejection, median and moving average filter
//
// One input beat is worked on at a time. A beat with frame_valid low is taken
// and dropped without leaving the idle state. A valid beat enters the history
// ring; when the quartiles are due, both history rings are re-ranked (one rank
// pass and one select pass around the ring of cells). The fence check first
// registers the spans, then compares; the median rings also take one rank pass
// and one select pass, the averaging divide is a multiply by a scaled
// reciprocal, the two squares are taken one after the other and the square root
// is found one bit at a time. A beat that emits also waits while the previous
// result is still held in the output register. The result sits in an output
// register, so the next beat is taken while it waits.
`default_nettype none
module iq_outlier_median_average_filter #(
	parameter int MEDIAN_TAPS    = 5,
	parameter int QUARTILE_DEPTH = 32,
	parameter int AVERAGE_LENGTH = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration writes
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_index,
	input  wire logic [7:0]   cfg_data,
	// sample beats
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [63:0]  s_axis_tdata,  // in_phase, quadrature, now_ms
	input  wire logic         s_axis_tuser,  // frame_valid
	// result beats
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata   // i_average, q_average, magnitude, time_ms, pad
);
	localparam int SW      = iqmaf_pkg::SAMPLE_W;
	localparam int IW      = iqmaf_pkg::IN_W;
	localparam int TW      = iqmaf_pkg::TIME_W;
	localparam int CW      = iqmaf_pkg::CFG_W;
	localparam int AW      = iqmaf_pkg::AVG_W;
	localparam int FW      = iqmaf_pkg::FENCE_W;
	localparam int SUM_W   = SW + $clog2(AVERAGE_LENGTH + 1);
	localparam int DVD_W   = SUM_W + iqmaf_pkg::FRAC_W;
	localparam int HCNT_W  = $clog2(QUARTILE_DEPTH + 1);
	localparam int MCNT_W  = $clog2(MEDIAN_TAPS + 1);
	localparam int ACNT_W  = $clog2(AVERAGE_LENGTH + 1);
	localparam logic [HCNT_W-1:0] HFULL = HCNT_W'(QUARTILE_DEPTH);
	localparam logic [MCNT_W-1:0] MFULL = MCNT_W'(MEDIAN_TAPS);
	localparam logic [ACNT_W-1:0] AFULL = ACNT_W'(AVERAGE_LENGTH);

	iqmaf_pkg::state_t state_q, state_d;

	logic [CW-1:0]     iqr_mult_q;
	logic [CW-1:0]     period_q;
	logic [SW-1:0]     ia_abs, qa_abs;
	logic [SW-1:0]     ia_q, qa_q;
	logic [TW-1:0]     time_q;
	logic [HCNT_W-1:0] hcnt_q, hcnt_next;
	logic [CW-1:0]     since_q, since_next;
	logic              qvalid_q;
	logic [MCNT_W-1:0] mcnt_q, mcnt_next;
	logic [ACNT_W-1:0] acnt_q, acnt_next;
	logic [SW-1:0]     avg_i_q [AVERAGE_LENGTH];
	logic [SW-1:0]     avg_q_q [AVERAGE_LENGTH];
	logic [SUM_W-1:0]  sum_i_q, sum_q_q;
	logic [FW-1:0]     span_i_s2, span_q_s2;
	logic              outlier;
	logic [AW-1:0]     ai_q, aq_q;
	logic [iqmaf_pkg::SQR_W-1:0] sq_i_s, sq_q_s;
	logic              in_take, valid_take, rank_due;

	iqmaf_pkg::rank_ctl_t hist_ctl, med_ctl;
	logic              hist_done_i, hist_done_q, med_done_i, med_done_q;
	logic [SW-1:0]     q1_i, q3_i, q1_q, q3_q, med_i, med_q, med_i_hi, med_q_hi;
	logic              div_start, div_done_i, div_done_q;
	logic [DVD_W-1:0]  quo_i, quo_q;
	logic              sqrt_start, sqrt_done;
	logic [iqmaf_pkg::ROOT_W-1:0] root;

	logic              out_valid_q;
	logic [AW-1:0]     out_i_q, out_q_q;
	logic [iqmaf_pkg::MAG_W-1:0] out_mag_q;
	logic [TW-1:0]     out_time_q;

	// absolute value with saturation of the most negative code
	function automatic logic [iqmaf_pkg::SAMPLE_W-1:0] abs_sat(
		input logic [iqmaf_pkg::IN_W-1:0] x
	);
		logic [iqmaf_pkg::IN_W-1:0] n;
		n = ~x + 1'b1;
		if (x == iqmaf_pkg::IN_MOST_NEG) begin
			return iqmaf_pkg::SAMPLE_MAX;
		end else if (x[iqmaf_pkg::IN_W-1]) begin
			return n[iqmaf_pkg::SAMPLE_W-1:0];
		end else begin
			return x[iqmaf_pkg::SAMPLE_W-1:0];
		end
	endfunction

	assign ia_abs     = abs_sat(s_axis_tdata[IW-1:0]);
	assign qa_abs     = abs_sat(s_axis_tdata[2*IW-1:IW]);
	assign in_take    = s_axis_tvalid && s_axis_tready;
	assign valid_take = in_take && s_axis_tuser;
	assign hcnt_next  = (hcnt_q == HFULL) ? hcnt_q : hcnt_q + 1'b1;
	assign since_next = (since_q == iqmaf_pkg::SINCE_MAX) ? since_q : since_q + 1'b1;
	assign rank_due   = (since_next >= period_q) && (hcnt_next == HFULL);
	assign mcnt_next  = (mcnt_q == MFULL) ? mcnt_q : mcnt_q + 1'b1;
	assign acnt_next  = (acnt_q == AFULL) ? acnt_q : acnt_q + 1'b1;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iqr_mult_q <= iqmaf_pkg::IQR_MULT_RST;
			period_q   <= iqmaf_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				iqmaf_pkg::REG_IQR_MULT: iqr_mult_q <= cfg_data;
				iqmaf_pkg::REG_PERIOD:   period_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// history rings, quartile positions at a quarter and three quarters
	assign hist_ctl.push  = valid_take;
	assign hist_ctl.start = (state_q == iqmaf_pkg::S_QSTART);

	iqmaf_rank_chain #(
		.DEPTH  (QUARTILE_DEPTH),
		.LO_POS (QUARTILE_DEPTH / 4),
		.HI_POS ((3 * QUARTILE_DEPTH) / 4)
	) u_hist_i (
		.clk (clk), .arst_n (arst_n), .ctl (hist_ctl), .din (ia_abs),
		.done (hist_done_i), .lo (q1_i), .hi (q3_i)
	);

	iqmaf_rank_chain #(
		.DEPTH  (QUARTILE_DEPTH),
		.LO_POS (QUARTILE_DEPTH / 4),
		.HI_POS ((3 * QUARTILE_DEPTH) / 4)
	) u_hist_q (
		.clk (clk), .arst_n (arst_n), .ctl (hist_ctl), .din (qa_abs),
		.done (hist_done_q), .lo (q1_q), .hi (q3_q)
	);

	// median rings
	assign med_ctl.push  = (state_q == iqmaf_pkg::S_FCMP) && !outlier;
	assign med_ctl.start = (state_q == iqmaf_pkg::S_MSTART);

	iqmaf_rank_chain #(
		.DEPTH  (MEDIAN_TAPS),
		.LO_POS (MEDIAN_TAPS / 2),
		.HI_POS (MEDIAN_TAPS / 2)
	) u_med_i (
		.clk (clk), .arst_n (arst_n), .ctl (med_ctl), .din (ia_q),
		.done (med_done_i), .lo (med_i), .hi (med_i_hi)
	);

	iqmaf_rank_chain #(
		.DEPTH  (MEDIAN_TAPS),
		.LO_POS (MEDIAN_TAPS / 2),
		.HI_POS (MEDIAN_TAPS / 2)
	) u_med_q (
		.clk (clk), .arst_n (arst_n), .ctl (med_ctl), .din (qa_q),
		.done (med_done_q), .lo (med_q), .hi (med_q_hi)
	);

	// fence test on the registered spans
	always_comb begin
		logic signed [FW-1:0] v_i, v_q, lo_i, lo_q, hi_i, hi_q;
		v_i  = FW'({ia_q, 4'b0});
		v_q  = FW'({qa_q, 4'b0});
		lo_i = FW'({q1_i, 4'b0}) - span_i_s2;
		hi_i = FW'({q3_i, 4'b0}) + span_i_s2;
		lo_q = FW'({q1_q, 4'b0}) - span_q_s2;
		hi_q = FW'({q3_q, 4'b0}) + span_q_s2;
		outlier = qvalid_q && ((v_i < lo_i) || (v_i > hi_i) ||
			(v_q < lo_q) || (v_q > hi_q));
	end

	// dividers for the two averages
	assign div_start = (state_q == iqmaf_pkg::S_DSTART);

	iqmaf_div #(.DVD_W (DVD_W), .DIVISOR (AVERAGE_LENGTH)) u_div_i (
		.clk (clk), .arst_n (arst_n), .start (div_start),
		.dividend ({sum_i_q, 8'b0}), .done (div_done_i), .quotient (quo_i)
	);

	iqmaf_div #(.DVD_W (DVD_W), .DIVISOR (AVERAGE_LENGTH)) u_div_q (
		.clk (clk), .arst_n (arst_n), .start (div_start),
		.dividend ({sum_q_q, 8'b0}), .done (div_done_q), .quotient (quo_q)
	);

	// magnitude
	assign sqrt_start = (state_q == iqmaf_pkg::S_RSTART);

	iqmaf_isqrt u_sqrt (
		.clk (clk), .arst_n (arst_n), .start (sqrt_start),
		.din (iqmaf_pkg::SQ_W'(sq_i_s) + iqmaf_pkg::SQ_W'(sq_q_s)),
		.done (sqrt_done), .root (root)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iqmaf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		case (state_q)
			iqmaf_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (valid_take) begin
					state_d = rank_due ? iqmaf_pkg::S_QSTART : iqmaf_pkg::S_FMUL;
				end
			end
			iqmaf_pkg::S_QSTART: state_d = iqmaf_pkg::S_QWAIT;
			iqmaf_pkg::S_QWAIT: begin
				if (hist_done_i && hist_done_q) begin
					state_d = iqmaf_pkg::S_FMUL;
				end
			end
			iqmaf_pkg::S_FMUL: state_d = iqmaf_pkg::S_FCMP;
			iqmaf_pkg::S_FCMP: begin
				if (outlier || mcnt_next != MFULL) begin
					state_d = iqmaf_pkg::S_IDLE;
				end else begin
					state_d = iqmaf_pkg::S_MSTART;
				end
			end
			iqmaf_pkg::S_MSTART: state_d = iqmaf_pkg::S_MWAIT;
			iqmaf_pkg::S_MWAIT: begin
				if (med_done_i && med_done_q) begin
					state_d = iqmaf_pkg::S_AVG;
				end
			end
			iqmaf_pkg::S_AVG: begin
				state_d = (acnt_next == AFULL) ? iqmaf_pkg::S_DSTART : iqmaf_pkg::S_IDLE;
			end
			iqmaf_pkg::S_DSTART: state_d = iqmaf_pkg::S_DWAIT;
			iqmaf_pkg::S_DWAIT: begin
				if (div_done_i && div_done_q) begin
					state_d = iqmaf_pkg::S_SQI;
				end
			end
			iqmaf_pkg::S_SQI:    state_d = iqmaf_pkg::S_SQQ;
			iqmaf_pkg::S_SQQ:    state_d = iqmaf_pkg::S_RSTART;
			iqmaf_pkg::S_RSTART: state_d = iqmaf_pkg::S_RWAIT;
			iqmaf_pkg::S_RWAIT: begin
				if (sqrt_done) begin
					state_d = iqmaf_pkg::S_EMIT;
				end
			end
			iqmaf_pkg::S_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					state_d = iqmaf_pkg::S_IDLE;
				end
			end
			default: state_d = iqmaf_pkg::S_IDLE;
		endcase
	end

	// counters, running sums and quartile flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q   <= '0;
			since_q  <= '0;
			qvalid_q <= 1'b0;
			mcnt_q   <= '0;
			acnt_q   <= '0;
			sum_i_q  <= '0;
			sum_q_q  <= '0;
		end else begin
			if (valid_take) begin
				hcnt_q  <= hcnt_next;
				since_q <= rank_due ? '0 : since_next;
				if (rank_due) begin
					qvalid_q <= 1'b1;
				end
			end
			if (med_ctl.push) begin
				mcnt_q <= mcnt_next;
			end
			if (state_q == iqmaf_pkg::S_AVG) begin
				acnt_q  <= acnt_next;
				sum_i_q <= sum_i_q + SUM_W'(med_i) -
					((acnt_q == AFULL) ? SUM_W'(avg_i_q[AVERAGE_LENGTH-1]) : '0);
				sum_q_q <= sum_q_q + SUM_W'(med_q) -
					((acnt_q == AFULL) ? SUM_W'(avg_q_q[AVERAGE_LENGTH-1]) : '0);
			end
		end
	end

	// sample capture, spans, average line, averages, squares
	always_ff @(posedge clk) begin
		if (valid_take) begin
			ia_q   <= ia_abs;
			qa_q   <= qa_abs;
			time_q <= s_axis_tdata[2*IW+TW-1:2*IW];
		end
		if (state_q == iqmaf_pkg::S_FMUL) begin
			span_i_s2 <= FW'(iqr_mult_q) * FW'(q3_i - q1_i);
			span_q_s2 <= FW'(iqr_mult_q) * FW'(q3_q - q1_q);
		end
		if (state_q == iqmaf_pkg::S_AVG) begin
			for (int i = AVERAGE_LENGTH - 1; i > 0; i--) begin
				avg_i_q[i] <= avg_i_q[i-1];
				avg_q_q[i] <= avg_q_q[i-1];
			end
			avg_i_q[0] <= med_i;
			avg_q_q[0] <= med_q;
		end
		if (state_q == iqmaf_pkg::S_DWAIT && div_done_i && div_done_q) begin
			ai_q <= AW'(quo_i);
			aq_q <= AW'(quo_q);
		end
		if (state_q == iqmaf_pkg::S_SQI) begin
			sq_i_s <= ai_q * ai_q;
		end
		if (state_q == iqmaf_pkg::S_SQQ) begin
			sq_q_s <= aq_q * aq_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == iqmaf_pkg::S_EMIT && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == iqmaf_pkg::S_EMIT && (!out_valid_q || m_axis_tready)) begin
			out_i_q    <= ai_q;
			out_q_q    <= aq_q;
			out_mag_q  <= root;
			out_time_q <= time_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b0, out_time_q, out_mag_q, out_q_q, out_i_q};

endmodule
`default_nettype wire

// ===== rtl/iqmaf_rank_chain.sv =====
// ring of ranking cells: each cell holds a value and its rank counts
`default_nettype none
module iqmaf_rank_chain #(
	parameter int DEPTH  = 32,
	parameter int LO_POS = 8,
	parameter int HI_POS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire iqmaf_pkg::rank_ctl_t                ctl,
	input  wire logic [iqmaf_pkg::SAMPLE_W-1:0]      din,
	output logic                                     done,
	output logic [iqmaf_pkg::SAMPLE_W-1:0]           lo,
	output logic [iqmaf_pkg::SAMPLE_W-1:0]           hi
);
	localparam int SW     = iqmaf_pkg::SAMPLE_W;
	localparam int RANK_W = $clog2(DEPTH + 1);
	localparam logic [RANK_W-1:0] LAST = RANK_W'(DEPTH - 1);
	localparam logic [RANK_W-1:0] LO_R = RANK_W'(LO_POS);
	localparam logic [RANK_W-1:0] HI_R = RANK_W'(HI_POS);

	logic [SW-1:0]     val_q  [DEPTH];
	logic [RANK_W-1:0] lt_q   [DEPTH];
	logic [RANK_W-1:0] le_q   [DEPTH];
	logic [SW-1:0]     vprev  [DEPTH];
	logic [SW-1:0]     vpush  [DEPTH];
	logic [RANK_W-1:0] ltprev [DEPTH];
	logic [RANK_W-1:0] leprev [DEPTH];
	logic [SW-1:0]     head;
	logic              busy_q;
	logic              sel_q;
	logic [RANK_W-1:0] cnt_q;
	logic [SW-1:0]     lo_q;
	logic [SW-1:0]     hi_q;

	assign head = val_q[DEPTH-1];

	// neighbor wiring of the ring
	for (genvar i = 0; i < DEPTH; i++) begin : g_link
		if (i == 0) begin : g_first
			assign vprev[i]  = val_q[DEPTH-1];
			assign ltprev[i] = lt_q[DEPTH-1];
			assign leprev[i] = le_q[DEPTH-1];
			assign vpush[i]  = din;
		end else begin : g_rest
			assign vprev[i]  = val_q[i-1];
			assign ltprev[i] = lt_q[i-1];
			assign leprev[i] = le_q[i-1];
			assign vpush[i]  = val_q[i-1];
		end
	end

	// cells: shift in on push, rotate and count while ranking
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctl.push && !busy_q) begin
				val_q[i] <= vpush[i];
			end else if (busy_q) begin
				val_q[i] <= vprev[i];
				if (!sel_q) begin
					lt_q[i] <= ltprev[i] + RANK_W'(head < vprev[i]);
					le_q[i] <= leprev[i] + RANK_W'(head <= vprev[i]);
				end else begin
					lt_q[i] <= ltprev[i];
					le_q[i] <= leprev[i];
				end
			end else if (ctl.start) begin
				lt_q[i] <= '0;
				le_q[i] <= '0;
			end
		end
	end

	// pass control: one rank pass, then one select pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (ctl.start) begin
				busy_q <= 1'b1;
				sel_q  <= 1'b0;
				cnt_q  <= '0;
			end
		end else if (cnt_q == LAST) begin
			cnt_q <= '0;
			if (sel_q) begin
				busy_q <= 1'b0;
			end
			sel_q <= ~sel_q;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// pick the head value whose rank span covers a wanted position
	always_ff @(posedge clk) begin
		if (busy_q && sel_q) begin
			if (lt_q[DEPTH-1] <= LO_R && LO_R < le_q[DEPTH-1]) begin
				lo_q <= head;
			end
			if (lt_q[DEPTH-1] <= HI_R && HI_R < le_q[DEPTH-1]) begin
				hi_q <= head;
			end
		end
	end

	assign done = busy_q && sel_q && (cnt_q == LAST);
	assign lo   = lo_q;
	assign hi   = hi_q;

endmodule
`default_nettype wire

// ===== rtl/iqmaf_div.sv =====
// divider by a constant: one registered multiply by a scaled reciprocal
`default_nettype none
module iqmaf_div #(
	parameter int DVD_W   = 27,
	parameter int DIVISOR = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);
	// reciprocal rounded up, scaled by 2^(DVD_W + ceil(log2(DIVISOR)))
	localparam int L_W   = $clog2(DIVISOR);
	localparam int SHIFT = DVD_W + L_W;
	localparam int M_W   = DVD_W + 1;
	localparam int P_W   = DVD_W + M_W;
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic [P_W-1:0] prod_q;
	logic           busy_q;

	// product with the reciprocal
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			prod_q <= P_W'(dividend) * P_W'(RECIP);
		end
	end

	// result ready in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start && !busy_q;
		end
	end

	assign done     = busy_q;
	assign quotient = DVD_W'(prod_q >> SHIFT);

endmodule
`default_nettype wire

// ===== rtl/iqmaf_isqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none
module iqmaf_isqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [iqmaf_pkg::SQ_W-1:0]      din,
	output logic                                 done,
	output logic [iqmaf_pkg::ROOT_W-1:0]         root
);
	localparam int SQ_W  = iqmaf_pkg::SQ_W;
	localparam int RT_W  = iqmaf_pkg::ROOT_W;
	localparam int REM_W = RT_W + 2;
	localparam int C_W   = $clog2(RT_W + 1);
	localparam logic [C_W-1:0] LAST = C_W'(RT_W - 1);

	logic [SQ_W-1:0]  x_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [RT_W-1:0]  root_q;
	logic [C_W-1:0]   cnt_q;
	logic             busy_q;

	assign rem_sh = {rem_q[REM_W-3:0], x_q[SQ_W-1:SQ_W-2]};
	assign trial  = {root_q, 2'b01};

	// datapath
	always_ff @(posedge clk) begin
		if (!busy_q && start) begin
			x_q    <= din;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= x_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RT_W-2:0], 1'b0};
			end
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (cnt_q == LAST) begin
			busy_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done = busy_q && (cnt_q == LAST);
	assign root = root_q;

endmodule
`default_nettype wire

// ===== rtl/iqmaf_checker.sv =====
// port checks of the filter top level and their binding
`default_nettype none
module iqmaf_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [103:0] m_axis_tdata
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	// a stalled result beat keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// a valid sample beat leaves the input not ready in the cycle after it is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("sample taken again right after a valid beat");

	// a new result appears only as the block returns to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result raised while still busy");

endmodule

bind iq_outlier_median_average_filter iqmaf_checker u_iqmaf_checker (.*);
`default_nettype wire

// ===== tb/iq_outlier_median_average_filter_tb.sv =====
// testbench of the i/q outlier rejection, median and moving average filter
`timescale 1ns / 100ps
`default_nettype none
module iq_outlier_median_average_filter_tb;

	localparam int HIST_DEPTH  = 32;
	localparam int MED_TAPS    = 5;
	localparam int AVG_LEN     = 8;
	localparam int AVG_SLOTS   = AVG_LEN + 1;
	localparam int SETTLE      = 400;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [iqmaf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

	typedef logic [iqmaf_pkg::SAMPLE_W-1:0] mag15_t;

	typedef struct packed {
		logic [iqmaf_pkg::AVG_W-1:0]  i_avg;
		logic [iqmaf_pkg::AVG_W-1:0]  q_avg;
		logic [iqmaf_pkg::MAG_W-1:0]  mag;
		logic [iqmaf_pkg::TIME_W-1:0] stamp;
	} filt_out_t;

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [7:0]    cfg_index;
	logic [7:0]    cfg_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [63:0]   s_axis_tdata;   // in_phase, quadrature, now_ms
	logic          s_axis_tuser;   // frame_valid
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [103:0]  m_axis_tdata;   // i_average, q_average, magnitude, time_ms, pad

	iq_outlier_median_average_filter uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// filter model state
	logic [7:0] fence_k16;
	logic [7:0] rerank_period;
	mag15_t     hist_i [HIST_DEPTH];
	mag15_t     hist_q [HIST_DEPTH];
	int         hist_fill, hist_wr;
	int         since_rank;
	mag15_t     quart [4];
	bit         quart_ok;
	mag15_t     med_i [MED_TAPS];
	mag15_t     med_q [MED_TAPS];
	int         med_fill, med_wr;
	logic [29:0] avg_ring [AVG_SLOTS];
	int         avg_fill, avg_wr;
	logic [31:0] sum_i, sum_q;

	filt_out_t  pending_averages [$];
	int         errors;
	int         send_idle_pct, recv_idle_pct;
	int         cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic mag15_t abs_clip(logic signed [iqmaf_pkg::IN_W-1:0] x);
		logic [iqmaf_pkg::IN_W:0] a;
		a = x[iqmaf_pkg::IN_W-1] ? 17'(-$signed({x[iqmaf_pkg::IN_W-1], x})) : {1'b0, x};
		return (a > iqmaf_pkg::SAMPLE_MAX) ? iqmaf_pkg::SAMPLE_MAX :
			a[iqmaf_pkg::SAMPLE_W-1:0];
	endfunction

	// insertion sort, then return entries n/4 and 3n/4
	function automatic void rank_ring(input mag15_t src [HIST_DEPTH],
			output mag15_t lo, output mag15_t hi);
		mag15_t t [HIST_DEPTH];
		mag15_t key;
		int j;
		t = src;
		for (int i = 1; i < HIST_DEPTH; i++) begin
			key = t[i];
			j = i;
			while (j > 0 && t[j-1] > key) begin
				t[j] = t[j-1];
				j--;
			end
			t[j] = key;
		end
		lo = t[HIST_DEPTH/4];
		hi = t[(3*HIST_DEPTH)/4];
	endfunction

	function automatic mag15_t middle_of(input mag15_t w [MED_TAPS]);
		int below, same;
		for (int i = 0; i < MED_TAPS; i++) begin
			below = 0;
			same = 0;
			for (int j = 0; j < MED_TAPS; j++) begin
				if (w[j] < w[i]) below++;
				else if (w[j] == w[i]) same++;
			end
			if (below <= MED_TAPS/2 && below + same > MED_TAPS/2) return w[i];
		end
		return '0;
	endfunction

	function automatic bit fenced_out(mag15_t v, mag15_t q1, mag15_t q3);
		longint span;
		span = longint'(fence_k16) * (longint'(q3) - longint'(q1));
		if (!quart_ok) return 1'b0;
		return 16*longint'(v) < 16*longint'(q1) - span ||
			16*longint'(v) > 16*longint'(q3) + span;
	endfunction

	function automatic logic [iqmaf_pkg::MAG_W-1:0] root_floor(longint unsigned x);
		longint unsigned r, t;
		r = 0;
		for (int b = iqmaf_pkg::MAG_W - 1; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r[iqmaf_pkg::MAG_W-1:0];
	endfunction

	// advance the model by one accepted beat
	task automatic predict_beat(bit fv, logic [15:0] ip, logic [15:0] qp, logic [31:0] ts);
		mag15_t ia, qa, mi, mq;
		logic [29:0] old;
		filt_out_t r;
		if (!fv) return;
		ia = abs_clip(ip);
		qa = abs_clip(qp);
		hist_i[hist_wr] = ia;
		hist_q[hist_wr] = qa;
		hist_wr = (hist_wr + 1) % HIST_DEPTH;
		if (hist_fill < HIST_DEPTH) hist_fill++;
		if (since_rank < 255) since_rank++;
		if (since_rank >= rerank_period && hist_fill == HIST_DEPTH) begin
			rank_ring(hist_i, quart[0], quart[1]);
			rank_ring(hist_q, quart[2], quart[3]);
			quart_ok = 1'b1;
			since_rank = 0;
		end
		if (fenced_out(ia, quart[0], quart[1]) || fenced_out(qa, quart[2], quart[3]))
			return;
		med_i[med_wr] = ia;
		med_q[med_wr] = qa;
		med_wr = (med_wr + 1) % MED_TAPS;
		if (med_fill < MED_TAPS) med_fill++;
		if (med_fill < MED_TAPS) return;
		mi = middle_of(med_i);
		mq = middle_of(med_q);
		avg_ring[avg_wr] = {mi, mq};
		sum_i += mi;
		sum_q += mq;
		if (avg_fill < AVG_SLOTS) avg_fill++;
		if (avg_fill == AVG_SLOTS) begin
			old = avg_ring[(avg_wr + 1) % AVG_SLOTS];
			sum_i -= old[29:15];
			sum_q -= old[14:0];
		end
		avg_wr = (avg_wr + 1) % AVG_SLOTS;
		if (avg_fill < AVG_LEN) return;
		r.i_avg = iqmaf_pkg::AVG_W'((64'(sum_i) << iqmaf_pkg::FRAC_W) / AVG_LEN);
		r.q_avg = iqmaf_pkg::AVG_W'((64'(sum_q) << iqmaf_pkg::FRAC_W) / AVG_LEN);
		r.mag = root_floor(longint'(r.i_avg) * r.i_avg + longint'(r.q_avg) * r.q_avg);
		r.stamp = ts;
		pending_averages.push_back(r);
	endtask

	// one sample beat, with a random gap in front
	task automatic send_sample(bit fv, logic [15:0] ip, logic [15:0] qp, logic [31:0] ts);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = fv;
		s_axis_tdata = {ts, qp, ip};
		do @(posedge clk); while (!s_axis_tready);
		predict_beat(fv, ip, qp, ts);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// wait out every result plus the block's longest latency
	task automatic drain;
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == iqmaf_pkg::REG_IQR_MULT) fence_k16 = val;
		else if (idx == iqmaf_pkg::REG_PERIOD) rerank_period = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// clustered samples around a random center, with outliers and dropped frames
	task automatic send_random(int valid_beats);
		int ci, cq, spread, vi, vq, sent;
		ci = $urandom_range(0, 32767);
		cq = $urandom_range(0, 32767);
		spread = $urandom_range(1, 3000);
		sent = 0;
		while (sent < valid_beats) begin
			if ($urandom_range(99) < 8) begin
				send_sample(1'b0, 16'($urandom), 16'($urandom), $urandom);
				continue;
			end
			if ($urandom_range(99) < 6) begin
				vi = $signed(16'($urandom));
				vq = $signed(16'($urandom));
			end else begin
				vi = ci + $urandom_range(0, 2*spread) - spread;
				vq = cq + $urandom_range(0, 2*spread) - spread;
				vi = (vi > 32767) ? 32767 : (vi < 0 ? 0 : vi);
				vq = (vq > 32767) ? 32767 : (vq < 0 ? 0 : vq);
				if ($urandom_range(1)) vi = -vi - $urandom_range(1);
				if ($urandom_range(1)) vq = -vq - $urandom_range(1);
			end
			send_sample(1'b1, 16'(vi), 16'(vq), $urandom);
			sent++;
		end
	endtask

	// extremes, dropped frames and the most negative sample
	task automatic test_directed;
		send_sample(1'b0, 16'h7FFF, 16'h8000, 32'hFFFF_FFFF);
		send_sample(1'b1, iqmaf_pkg::IN_MOST_NEG, iqmaf_pkg::IN_MOST_NEG, 32'hFFFF_FFFF);
		send_sample(1'b1, 16'h7FFF, 16'h7FFF, 32'h0);
		send_sample(1'b1, 16'h0, 16'h0, 32'h8000_0001);
		send_sample(1'b1, 16'hFFFF, 16'h0001, 32'h5555_5555);
		for (int n = 0; n < 16; n++)
			send_sample(1'b1, 16'(n * 2000 - 16000), 16'(16000 - n * 1900), 32'(n));
		send_sample(1'b0, 16'h0, 16'h0, 32'h0);
	endtask

	// default registers, then the tightest fence; the widest fence and an unused register are only written
	task automatic test_fence;
		send_random(150);
		drain();
		write_reg(iqmaf_pkg::REG_IQR_MULT, 8'd0);
		send_random(150);
		drain();
		write_reg(iqmaf_pkg::REG_IQR_MULT, 8'd255);
		write_reg(REG_UNUSED, 8'hA5);
	endtask

	// quartile refresh at its fastest, slowest and zero period
	task automatic test_period;
		write_reg(iqmaf_pkg::REG_PERIOD, 8'd1);
		send_random(150);
		drain();
		write_reg(iqmaf_pkg::REG_PERIOD, 8'd255);
		write_reg(iqmaf_pkg::REG_IQR_MULT, 8'd16);
		send_random(150);
		drain();
		write_reg(iqmaf_pkg::REG_PERIOD, 8'd0);
		send_random(150);
		drain();
	endtask

	// last burst, then single beats each held back until no result is still expected
	task automatic test_drained_beats;
		write_reg(iqmaf_pkg::REG_PERIOD, 8'd10);
		write_reg(iqmaf_pkg::REG_IQR_MULT, 8'd40);
		send_random(120);
		for (int n = 0; n < 10; n++) begin
			while (pending_averages.size() != 0) @(posedge clk);
			@(negedge clk);
			send_random(1);
		end
	endtask

	// random receiver stalls
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		filt_out_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.i_avg = m_axis_tdata[22:0];
			got.q_avg = m_axis_tdata[45:23];
			got.mag = m_axis_tdata[69:46];
			got.stamp = m_axis_tdata[101:70];
			if (pending_averages.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = pending_averages.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch i %h/%h q %h/%h mag %h/%h t %h/%h",
							want.i_avg, got.i_avg, want.q_avg, got.q_avg,
							want.mag, got.mag, want.stamp, got.stamp);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("iq_outlier_median_average_filter_tb: errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		errors = 0;
		cycles = 0;
		fence_k16 = iqmaf_pkg::IQR_MULT_RST;
		rerank_period = iqmaf_pkg::PERIOD_RST;
		hist_i = '{default: '0};
		hist_q = '{default: '0};
		quart = '{default: '0};
		med_i = '{default: '0};
		med_q = '{default: '0};
		avg_ring = '{default: '0};
		hist_fill = 0; hist_wr = 0; since_rank = 0; quart_ok = 1'b0;
		med_fill = 0; med_wr = 0; avg_fill = 0; avg_wr = 0;
		sum_i = '0; sum_q = '0;
		send_idle_pct = 9;
		recv_idle_pct = 77;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_fence();
		send_idle_pct = 77;
		recv_idle_pct = 9;
		test_period();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_drained_beats();
		drain();

		if (errors == 0)
			$display("iq_outlier_median_average_filter_tb: clean");
		else
			$display("iq_outlier_median_average_filter_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== iq_outlier_median_average_filter.f =====
rtl/iqmaf_pkg.sv
rtl/iqmaf_rank_chain.sv
rtl/iqmaf_div.sv
rtl/iqmaf_isqrt.sv
rtl/iq_outlier_median_average_filter.sv
rtl/iqmaf_checker.sv
tb/iq_outlier_median_average_filter_tb.sv
